// File: design/sfr_pkg.sv
// Package: payload structs, register indexes and shared constants for stream_find_replace.
package sfr_pkg;

  localparam int CNT_W         = 4;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int DEF_MAX_PATTERN     = 8;
  localparam int DEF_MAX_REPLACEMENT = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 4'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [63:0]      pattern_bytes;
    logic [CNT_W-1:0] pattern_len;
    logic [63:0]      replacement_bytes;
    logic [CNT_W-1:0] replacement_len;
  } cfg_t;

endpackage

// File: design/sfr_window.sv
// Pending window, pattern compare and burst builder for stream_find_replace.
module sfr_window #(
  parameter int MAX_PATTERN = 8,
  parameter int BURST_DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic                     clear,
  input  sfr_pkg::in_t             in_data,
  input  sfr_pkg::cfg_t            cfg,
  output logic [7:0]               burst_bytes [BURST_DEPTH],
  output logic [sfr_pkg::CNT_W-1:0] burst_count
);
  import sfr_pkg::*;

  localparam int APP_DEPTH = BURST_DEPTH + 1;

  logic [7:0]       win [MAX_PATTERN];
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [7:0]       win_app [APP_DEPTH];
  logic [7:0]       win_next [MAX_PATTERN];
  logic             full;
  logic             match;

  always_comb begin
    for (int i = 0; i < APP_DEPTH; i++) begin
      win_app[i] = in_data.in_byte;
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (CNT_W'(i) < cnt) begin
        win_app[i] = win[i];
      end
    end
    full  = ({1'b0, cnt} + (CNT_W+1)'(1)) >= {1'b0, cfg.pattern_len};
    match = full;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (CNT_W'(i) < cfg.pattern_len && win_app[i] != cfg.pattern_bytes[8*i +: 8]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < BURST_DEPTH; i++) begin
      burst_bytes[i] = match ? cfg.replacement_bytes[8*i +: 8] : win_app[i];
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_next[i] = full ? win_app[i+1] : win_app[i];
    end
    if (match) begin
      burst_count = cfg.replacement_len;
      cnt_next    = '0;
    end else if (full) begin
      burst_count = in_data.end_of_stream ? cnt + CNT_W'(1) : CNT_W'(1);
      cnt_next    = in_data.end_of_stream ? '0 : cnt;
    end else begin
      burst_count = in_data.end_of_stream ? cnt + CNT_W'(1) : '0;
      cnt_next    = in_data.end_of_stream ? '0 : cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (clear) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

endmodule

// File: design/stream_find_replace.sv
// Top level of stream_find_replace: config registers, window and output burst.
//
// Streaming find-and-replace over a byte stream. Input beats carry one text
// byte and an end_of_stream flag; output beats carry one rewritten byte and
// a last flag set on the final byte produced by that input beat. A pattern
// of 1 to MAX_PATTERN bytes is replaced by 0 to MAX_REPLACEMENT bytes,
// leftmost and without overlap; end_of_stream flushes pending bytes.
// The config channel writes pattern_bytes, pattern_length,
// replacement_bytes and replacement_length by index; it is always ready.
// Writing pattern_length drops all pending bytes. Write config only while
// the block is idle.
// The first output byte of an input beat appears in the cycle after the
// beat is accepted. An input beat that yields n bytes occupies the output
// burst register until all n have left; a new input beat is taken in the
// cycle the last of them leaves, so the rate is one beat per cycle while
// each beat yields at most one byte and the receiver does not stall.
// When the receiver stalls, the burst register holds and in_ready drops.
// Reset empties the window and the burst and restores pattern_length to 1.
module stream_find_replace #(
  parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sfr_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sfr_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sfr_pkg::*;

  localparam int BURST_DEPTH = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN :
                               ((MAX_REPLACEMENT > 0) ? MAX_REPLACEMENT : 1);

  logic [63:0]      pattern_bytes;
  logic [CNT_W-1:0] pattern_length;
  logic [63:0]      replacement_bytes;
  logic [CNT_W-1:0] replacement_length;
  cfg_t             cfg;
  logic             cfg_write;
  logic             in_accept;
  logic             out_accept;
  logic [7:0]       burst_bytes [BURST_DEPTH];
  logic [CNT_W-1:0] burst_count;
  logic [7:0]       bb [BURST_DEPTH];
  logic [CNT_W-1:0] rem;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign out_valid  = rem != '0;
  assign out_accept = out_valid && out_ready;
  assign in_ready   = (rem == '0) || (rem == CNT_W'(1) && out_ready);
  assign in_accept  = in_valid && in_ready;
  assign out_data.out_byte = bb[0];
  assign out_data.last     = rem == CNT_W'(1);

  always_comb begin
    cfg.pattern_bytes     = pattern_bytes;
    cfg.replacement_bytes = replacement_bytes;
    if (pattern_length == '0) begin
      cfg.pattern_len = CNT_W'(1);
    end else if (pattern_length > CNT_W'(MAX_PATTERN)) begin
      cfg.pattern_len = CNT_W'(MAX_PATTERN);
    end else begin
      cfg.pattern_len = pattern_length;
    end
    if (replacement_length > CNT_W'(MAX_REPLACEMENT)) begin
      cfg.replacement_len = CNT_W'(MAX_REPLACEMENT);
    end else begin
      cfg.replacement_len = replacement_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= CNT_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[CNT_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sfr_window #(
    .MAX_PATTERN (MAX_PATTERN),
    .BURST_DEPTH (BURST_DEPTH)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .clear       (cfg_write && cfg_index == REG_PATTERN_LENGTH),
    .in_data     (in_data),
    .cfg         (cfg),
    .burst_bytes (burst_bytes),
    .burst_count (burst_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (in_accept) begin
      rem <= burst_count;
    end else if (out_accept) begin
      rem <= rem - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      bb <= burst_bytes;
    end else if (out_accept) begin
      for (int i = 0; i < BURST_DEPTH - 1; i++) begin
        bb[i] <= bb[i+1];
      end
    end
  end

  a_burst_bound: assert property (@(posedge clk) disable iff (rst)
    rem <= CNT_W'(BURST_DEPTH))
    else $error("burst count exceeds burst depth");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    out_accept && out_data.last && !in_accept |=> !out_valid)
    else $error("output continues after last beat with no new input");

  a_stall_keeps_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && rem == $past(rem))
    else $error("burst changed while receiver stalled");

endmodule

// File: tb/tb_stream_find_replace.sv
`timescale 1ns / 1ps
// Testbench for stream_find_replace: directed and random text checked beat by beat.
module tb_stream_find_replace;
  import sfr_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 19;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  stream_find_replace u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [63:0] pat_bytes;
  logic [3:0]  pat_len;
  logic [63:0] rep_bytes;
  logic [3:0]  rep_len;
  logic [7:0]  win_bytes [8];
  int          win_count;
  out_t        rewritten_q [$];
  out_t        want_beat;

  int errors        = 0;
  int cycles        = 0;
  int rx_hold_req   = 0;
  int rx_left       = 0;
  int rx_phase_left = 0;
  int rx_style      = 0;
  bit tx_steady     = 1'b0;
  int burst_left    = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: long hold on request, otherwise random stall styles in stretches
  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_left > 0) begin
      rx_left = rx_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_style = $urandom_range(0, 2);
        rx_phase_left = $urandom_range(8, 64);
      end
      rx_phase_left = rx_phase_left - 1;
      case (rx_style)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (rewritten_q.size() == 0) begin
        $error("unexpected beat: out_byte %h last %b", out_data.out_byte, out_data.last);
        errors++;
      end else begin
        want_beat = rewritten_q.pop_front();
        if (out_data.out_byte !== want_beat.out_byte) begin
          $error("out_byte: expected %h, actual %h", want_beat.out_byte, out_data.out_byte);
          errors++;
        end
        if (out_data.last !== want_beat.last) begin
          $error("last: expected %b, actual %b", want_beat.last, out_data.last);
          errors++;
        end
      end
    end
  end

  function automatic int pat_eff();
    if (pat_len == 4'd0) return 1;
    if (pat_len > 4'd8) return 8;
    return int'(pat_len);
  endfunction

  function automatic int rep_eff();
    if (rep_len > 4'd8) return 8;
    return int'(rep_len);
  endfunction

  task automatic rewrite_byte(input logic [7:0] b, input logic eos);
    out_t res [$];
    bit   hit;
    int   plen;
    plen = pat_eff();
    if (win_count > 7) win_count = 7;
    win_bytes[win_count] = b;
    win_count++;
    if (win_count >= plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++)
        if (win_bytes[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        for (int i = 0; i < rep_eff(); i++)
          if (res.size() < 8) res.push_back(out_t'{out_byte: rep_bytes[8*i +: 8], last: 1'b0});
        win_count = 0;
      end else begin
        if (res.size() < 8) res.push_back(out_t'{out_byte: win_bytes[0], last: 1'b0});
        for (int i = 0; i < 7; i++) win_bytes[i] = win_bytes[i+1];
        win_count--;
      end
    end
    if (eos) begin
      for (int i = 0; i < win_count; i++)
        if (res.size() < 8) res.push_back(out_t'{out_byte: win_bytes[i], last: 1'b0});
      win_count = 0;
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) rewritten_q.push_back(res[i]);
  endtask

  task automatic send_beat(input logic [7:0] b, input logic eos);
    int gap;
    if (!tx_steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_data  <= in_t'{in_byte: b, end_of_stream: eos};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    rewrite_byte(b, eos);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val, input bit keep);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (!keep) cfg_valid <= 1'b0;
    case (idx)
      REG_PATTERN_BYTES: pat_bytes = val;
      REG_PATTERN_LENGTH: begin
        pat_len = val[3:0];
        win_count = 0;
      end
      REG_REPLACEMENT_BYTES: rep_bytes = val;
      REG_REPLACEMENT_LENGTH: rep_len = val[3:0];
      default: ;
    endcase
  endtask

  // length registers get random upper bits, which must be ignored
  task automatic configure(input logic [63:0] pb, input logic [3:0] pl,
                           input logic [63:0] rb, input logic [3:0] rl);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_PATTERN_BYTES, pb, 1'b1);
    write_reg(REG_PATTERN_LENGTH, {junk[63:4], pl}, 1'b1);
    write_reg(REG_REPLACEMENT_BYTES, rb, 1'b1);
    write_reg(REG_REPLACEMENT_LENGTH, {junk[31:0], junk[63:36], rl}, 1'b0);
  endtask

  task automatic test_defaults();
    send_beat(8'h00, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'hFF, 1'b1);
  endtask

  task automatic test_long_pattern();
    wait_idle();
    configure(64'hFF00_A55A_0180_7F01, 4'hF, 64'h0123_4567_89AB_CDEF, 4'hF);
    for (int i = 0; i < 8; i++) send_beat(pat_bytes[8*i +: 8], 1'b0);
  endtask

  task automatic test_midstream_length();
    wait_idle();
    for (int i = 0; i < 3; i++) send_beat(pat_bytes[8*i +: 8], 1'b0);
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, 64'd2, 1'b0);
    send_beat(pat_bytes[7:0], 1'b0);
    send_beat(pat_bytes[15:8], 1'b1);
  endtask

  task automatic test_length_zero();
    wait_idle();
    configure(64'h0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    send_beat(8'h00, 1'b1);
    send_beat(8'h01, 1'b1);
  endtask

  task automatic test_flush();
    wait_idle();
    configure(64'h7A7978, 4'd3, 64'h4241, 4'd2);
    send_beat(8'h78, 1'b0);
    send_beat(8'h79, 1'b0);
    send_beat(8'h71, 1'b1);
  endtask

  // hold the receiver while offering expanding bytes so the block stalls its input
  task automatic test_backpressure();
    wait_idle();
    configure(64'h5A, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    rx_hold_req = 300;
    tx_steady = 1'b1;
    for (int i = 0; i < 16; i++)
      send_beat((i % 3 == 2) ? 8'($urandom) : 8'h5A, (i == 15));
    tx_steady = 1'b0;
  endtask

  task automatic test_random();
    logic [7:0]  alpha [4];
    logic [7:0]  text_q [$];
    logic [63:0] pb;
    logic [3:0]  pl, rl;
    int          r, plen, cut;
    bit          end_eos;
    logic        eos;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      foreach (alpha[i]) alpha[i] = 8'($urandom);
      pb = {$urandom, $urandom};
      r = $urandom_range(0, 9);
      case (r)
        0: pl = 4'd0;
        1: pl = 4'($urandom_range(9, 15));
        2: pl = 4'd8;
        default: pl = 4'($urandom_range(1, 4));
      endcase
      r = $urandom_range(0, 9);
      case (r)
        0: rl = 4'd0;
        1: rl = 4'd8;
        2: rl = 4'($urandom_range(9, 15));
        default: rl = 4'($urandom_range(1, 3));
      endcase
      for (int i = 0; i < 8; i++) pb[8*i +: 8] = alpha[$urandom_range(0, 3)];
      if (ph == 1) pb = 64'h0;
      if (ph == 2) pb = 64'hFFFF_FFFF_FFFF_FFFF;
      if (ph == 1 || ph == 2) foreach (alpha[i]) alpha[i] = pb[7:0] ^ 8'(i);
      configure(pb, pl, {$urandom, $urandom}, rl);
      plen = pat_eff();
      tx_steady = ($urandom_range(0, 3) == 0);
      end_eos = ($urandom_range(0, 3) != 0);
      text_q.delete();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (text_q.size() == 0) begin
          r = $urandom_range(0, 9);
          if (r < 4) begin
            for (int i = 0; i < plen; i++) text_q.push_back(pat_bytes[8*i +: 8]);
          end else if (r < 7) begin
            text_q.push_back(alpha[$urandom_range(0, 3)]);
          end else if (r < 9) begin
            cut = $urandom_range(0, plen - 1);
            for (int i = 0; i < cut; i++) text_q.push_back(pat_bytes[8*i +: 8]);
            text_q.push_back(8'($urandom));
          end else begin
            text_q.push_back(8'($urandom));
          end
        end
        eos = ((k == PHASE_ITEMS - 1) && end_eos) || ($urandom_range(0, 24) == 0);
        if (ph == 3 && k == PHASE_ITEMS / 2) wait_idle();
        send_beat(text_q.pop_front(), eos);
      end
    end
    tx_steady = 1'b0;
  endtask

  initial begin
    pat_bytes = '0;
    pat_len   = 4'd1;
    rep_bytes = '0;
    rep_len   = 4'd0;
    foreach (win_bytes[i]) win_bytes[i] = 8'h00;
    win_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_long_pattern();
    test_midstream_length();
    test_length_zero();
    test_flush();
    test_backpressure();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/sfr_pkg.sv
design/sfr_window.sv
design/stream_find_replace.sv
tb/tb_stream_find_replace.sv
